### rtl/core/ptfk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfk_pkg: shared constants, types and functions
// Fixed-point constants for the pan-tilt forward kinematics pipeline.
// ----------------------------------------------------------------------------
package ptfk_pkg;

    localparam int ANGLE_W      = 15;
    localparam int CFG_W        = 16;
    localparam int POS_W        = 19;
    localparam int CFG_IDX_W    = 3;
    localparam int DEF_TRIG_ITERATIONS = 16;

    localparam int CW  = 34;    // CORDIC x/y/z datapath width (Q30 with headroom)
    localparam int QW  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ARM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JOINT  = 3'd4;

    localparam logic [14:0] FULL_TURN    = 15'd23040;
    localparam logic [14:0] QUARTER_TURN = 15'd5760;
    localparam logic [18:0] RAD_PER_UNIT = 19'd292818;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [15:0] ARM_RST    = 16'd4005;
    localparam logic [15:0] BASE_X_RST = 16'd2048;
    localparam logic [15:0] BASE_Y_RST = 16'd2211;
    localparam logic [15:0] BASE_Z_RST = 16'd4682;
    localparam logic [15:0] JOINT_RST  = 16'd4608;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [QW-1:0]        quad;
    } t_rot;

    function automatic logic signed [CW-1:0] atan_step(input int i);
        logic signed [CW-1:0] v;
        begin
            unique case (i)
                0: v = 34'sd843314857;
                1: v = 34'sd497837829;
                2: v = 34'sd263043837;
                3: v = 34'sd133525159;
                4: v = 34'sd67021687;
                5: v = 34'sd33543516;
                6: v = 34'sd16775851;
                7: v = 34'sd8388437;
                8: v = 34'sd4194283;
                9: v = 34'sd2097149;
                default: v = (i <= 30) ? (34'sd1 <<< (30 - i)) : '0;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/core/pan_tilt_forward_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_forward_kinematics: pan/tilt angles to tip position
// Unrolled CORDIC chain followed by a multiply/add pipeline.
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled. The pipe is one input
// register, one CORDIC cell per iteration, then three multiply/round stages and an
// output register. The whole pipe advances when the output register is empty
// or being taken, so a stall on the output holds every stage.
module pan_tilt_forward_kinematics #(
    parameter int TRIG_ITERATIONS = ptfk_pkg::DEF_TRIG_ITERATIONS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [ptfk_pkg::ANGLE_W-1:0]   i_pan_angle,
    input  logic signed [ptfk_pkg::ANGLE_W-1:0]   i_tilt_angle,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [ptfk_pkg::POS_W-1:0]     o_pos_x,
    output logic signed [ptfk_pkg::POS_W-1:0]     o_pos_y,
    output logic signed [ptfk_pkg::POS_W-1:0]     o_pos_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ptfk_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ptfk_pkg::CFG_W-1:0]            i_cfg_data
);
    import ptfk_pkg::*;

    localparam int NST = TRIG_ITERATIONS + 5;

    logic en;
    logic [NST-1:0] r_vld;
    logic [15:0] r_arm, r_bx, r_by, r_bz, r_jh;

    assign en          = !r_vld[NST-1] || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm <= ARM_RST;
            r_bx  <= BASE_X_RST;
            r_by  <= BASE_Y_RST;
            r_bz  <= BASE_Z_RST;
            r_jh  <= JOINT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ARM:    r_arm <= i_cfg_data;
                REG_BASE_X: r_bx  <= i_cfg_data;
                REG_BASE_Y: r_by  <= i_cfg_data;
                REG_BASE_Z: r_bz  <= i_cfg_data;
                REG_JOINT:  r_jh  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (en)
            r_vld <= {r_vld[NST-2:0], i_valid};
    end

    t_rot n_p0, n_t0;
    t_rot r_p0, r_t0;
    t_rot cp [TRIG_ITERATIONS+1];
    t_rot ct [TRIG_ITERATIONS+1];

    ptfk_prep u_prep_p (.i_angle(i_pan_angle),  .o_rot(n_p0));
    ptfk_prep u_prep_t (.i_angle(i_tilt_angle), .o_rot(n_t0));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0 <= n_p0;
            r_t0 <= n_t0;
        end
    end

    assign cp[0] = r_p0;
    assign ct[0] = r_t0;

    for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_cell
        ptfk_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_pan (cp[g]),
            .i_tilt(ct[g]),
            .o_pan (cp[g+1]),
            .o_tilt(ct[g+1])
        );
    end

    // quadrant fold
    logic signed [CW-1:0] sp, cpn, st, ctn;
    always_comb begin
        unique case (cp[TRIG_ITERATIONS].quad)
            2'd0: begin sp = cp[TRIG_ITERATIONS].y;  cpn = cp[TRIG_ITERATIONS].x;  end
            2'd1: begin sp = cp[TRIG_ITERATIONS].x;  cpn = -cp[TRIG_ITERATIONS].y; end
            2'd2: begin sp = -cp[TRIG_ITERATIONS].y; cpn = -cp[TRIG_ITERATIONS].x; end
            default: begin sp = -cp[TRIG_ITERATIONS].x; cpn = cp[TRIG_ITERATIONS].y; end
        endcase
        unique case (ct[TRIG_ITERATIONS].quad)
            2'd0: begin st = ct[TRIG_ITERATIONS].y;  ctn = ct[TRIG_ITERATIONS].x;  end
            2'd1: begin st = ct[TRIG_ITERATIONS].x;  ctn = -ct[TRIG_ITERATIONS].y; end
            2'd2: begin st = -ct[TRIG_ITERATIONS].y; ctn = -ct[TRIG_ITERATIONS].x; end
            default: begin st = -ct[TRIG_ITERATIONS].x; ctn = ct[TRIG_ITERATIONS].y; end
        endcase
    end

    // stage A: arm*sin_t, arm*cos_t (17x34)
    logic signed [50:0] r_ast, r_act;
    logic signed [CW-1:0] r_sp1, r_cp1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ast <= $signed({1'b0, r_arm}) * st;
            r_act <= $signed({1'b0, r_arm}) * ctn;
            r_sp1 <= sp;
            r_cp1 <= cpn;
        end
    end

    // stage B: rs = round(arm*sin_t / 2^15), z term
    logic signed [50:0] n_rs_full, n_z_full;
    logic signed [35:0] r_rs;
    logic signed [20:0] r_zt;
    logic signed [CW-1:0] r_sp2, r_cp2;
    always_comb begin
        n_rs_full = (r_ast + 51'sd16384) >>> 15;
        n_z_full  = (r_act + 51'sd536870912) >>> 30;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rs  <= n_rs_full[35:0];
            r_zt  <= n_z_full[20:0];
            r_sp2 <= r_sp1;
            r_cp2 <= r_cp1;
        end
    end

    // stage C: rs * trig (split into two 17-bit halves of trig)
    logic signed [52:0] r_xl, r_yl;
    logic signed [52:0] r_xh, r_yh;
    logic signed [20:0] r_zt3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xl  <= r_rs * $signed({1'b0, r_cp2[16:0]});
            r_yl  <= r_rs * $signed({1'b0, r_sp2[16:0]});
            r_xh  <= r_rs * $signed(r_cp2[CW-1:17]);
            r_yh  <= r_rs * $signed(r_sp2[CW-1:17]);
            r_zt3 <= r_zt;
        end
    end

    logic signed [71:0] px_p, py_p;
    logic signed [71:0] px_r, py_r;
    logic signed [23:0] px, py, pz;
    logic signed [POS_W-1:0] n_x, n_y, n_z;

    function automatic logic signed [POS_W-1:0] sat(input logic signed [23:0] v);
        if (v < -24'sd262144)     return $signed(19'h40000);
        else if (v > 24'sd262143) return 19'sd262143;
        else                      return v[POS_W-1:0];
    endfunction

    always_comb begin
        px_p = (72'(r_xh) <<< 17) + 72'(r_xl) + (72'sd1 <<< 44);
        py_p = (72'(r_yh) <<< 17) + 72'(r_yl) + (72'sd1 <<< 44);
        px_r = px_p >>> 45;
        py_r = py_p >>> 45;
        px = 24'(px_r) + $signed({8'd0, r_bx});
        py = -24'(py_r) + $signed({8'd0, r_by});
        pz = 24'(r_zt3) + $signed({8'd0, r_jh}) + $signed({8'd0, r_bz});
        n_x = sat(px);
        n_y = sat(py);
        n_z = sat(pz);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pos_x <= n_x;
            o_pos_y <= n_y;
            o_pos_z <= n_z;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x) && $stable(o_pos_z))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipe stalled with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("pipe moved while stalled");
endmodule

### rtl/core/ptfk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfk_cell: one CORDIC rotation cell
// Registers one micro-rotation of two angle lanes per cycle while enabled.
// ----------------------------------------------------------------------------
module ptfk_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  ptfk_pkg::t_rot i_pan,
    input  ptfk_pkg::t_rot i_tilt,
    output ptfk_pkg::t_rot o_pan,
    output ptfk_pkg::t_rot o_tilt
);
    import ptfk_pkg::*;

    localparam logic signed [CW-1:0] ATAN = atan_step(STEP);

    t_rot n_pan, n_tilt, r_pan, r_tilt;

    function automatic t_rot rotate(input t_rot a);
        t_rot b;
        logic signed [CW-1:0] dx, dy;
        begin
            dx = a.y >>> STEP;
            dy = a.x >>> STEP;
            b = a;
            if (!a.z[CW-1]) begin
                b.x = a.x - dx;
                b.y = a.y + dy;
                b.z = a.z - ATAN;
            end else begin
                b.x = a.x + dx;
                b.y = a.y - dy;
                b.z = a.z + ATAN;
            end
            return b;
        end
    endfunction

    always_comb begin
        n_pan  = rotate(i_pan);
        n_tilt = rotate(i_tilt);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pan  <= n_pan;
            r_tilt <= n_tilt;
        end
    end

    assign o_pan  = r_pan;
    assign o_tilt = r_tilt;
endmodule

### rtl/core/ptfk_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptfk_prep: angle reduction
// Reduces an angle to one turn, splits quadrant, converts to Q30 radians.
// ----------------------------------------------------------------------------
module ptfk_prep (
    input  logic signed [ptfk_pkg::ANGLE_W-1:0] i_angle,
    output ptfk_pkg::t_rot                      o_rot
);
    import ptfk_pkg::*;

    logic signed [15:0] a0;
    logic [14:0]        a1;
    logic [12:0]        rem;
    logic [QW-1:0]      quad;
    logic [31:0]        prod;

    always_comb begin
        a0 = {i_angle[ANGLE_W-1], i_angle};
        if (a0 < 0)
            a0 = a0 + $signed({1'b0, FULL_TURN});
        a1 = a0[14:0];
        if (a1 >= FULL_TURN)
            a1 = a1 - FULL_TURN;
        if (a1 >= 15'd17280) begin
            quad = 2'd3;
            rem  = 13'(a1 - 15'd17280);
        end else if (a1 >= 15'd11520) begin
            quad = 2'd2;
            rem  = 13'(a1 - 15'd11520);
        end else if (a1 >= QUARTER_TURN) begin
            quad = 2'd1;
            rem  = 13'(a1 - QUARTER_TURN);
        end else begin
            quad = 2'd0;
            rem  = a1[12:0];
        end
        prod = 32'(rem) * 32'(RAD_PER_UNIT);
        o_rot.x    = CORDIC_GAIN;
        o_rot.y    = '0;
        o_rot.z    = $signed({2'b00, prod});
        o_rot.quad = quad;
    end
endmodule

### sim/pan_tilt_forward_kinematics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_forward_kinematics_tb: self-checking bench for the pan/tilt block
// Streams angle pairs under random bursts, gaps and output stalls, predicts
// the tip position with a bit-exact CORDIC model and compares every result.
// Geometry registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module pan_tilt_forward_kinematics_tb;
    import ptfk_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_tip_pos;

    class tip_scoreboard;
        t_tip_pos   pending_q[$];
        longint     geom[5];
        int         mismatches;
        int         n_items;
        int         n_results;

        function new();
            geom[REG_ARM]    = ARM_RST;
            geom[REG_BASE_X] = BASE_X_RST;
            geom[REG_BASE_Y] = BASE_Y_RST;
            geom[REG_BASE_Z] = BASE_Z_RST;
            geom[REG_JOINT]  = JOINT_RST;
            mismatches = 0;
            n_items = 0;
            n_results = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx <= REG_JOINT) geom[idx] = val;
        endfunction

        function longint atan_q30(int i);
            longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                33543516, 16775851, 8388437, 4194283, 2097149};
            if (i < 10) return tbl[i];
            return longint'(1) << (30 - i);
        endfunction

        function void trig(logic signed [ANGLE_W-1:0] ang, output longint s,
                           output longint c);
            longint a, x, y, z, dx, dy;
            int quad;
            a = ang;
            quad = 0;
            x = 652032874;
            y = 0;
            if (a < 0) a += 23040;
            while (a >= 5760 && quad < 3) begin
                a -= 5760;
                quad++;
            end
            z = a * 292818;
            for (int i = 0; i < DEF_TRIG_ITERATIONS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_q30(i);
                end else begin
                    x += dx; y -= dy; z += atan_q30(i);
                end
            end
            case (quad)
                0: begin s = y;  c = x;  end
                1: begin s = x;  c = -y; end
                2: begin s = -y; c = -x; end
                default: begin s = -x; c = y; end
            endcase
        endfunction

        function logic signed [POS_W-1:0] clamp(longint v);
            if (v < -262144) v = -262144;
            if (v > 262143) v = 262143;
            return POS_W'(v);
        endfunction

        function longint rnd(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function void note_item(logic signed [ANGLE_W-1:0] pan,
                                logic signed [ANGLE_W-1:0] tilt);
            longint sp, cp, st, ct, rs;
            t_tip_pos e;
            trig(pan, sp, cp);
            trig(tilt, st, ct);
            rs = rnd(geom[REG_ARM] * st, 15);
            e.x = clamp(rnd(rs * cp, 45) + geom[REG_BASE_X]);
            e.y = clamp(-rnd(rs * sp, 45) + geom[REG_BASE_Y]);
            e.z = clamp(rnd(geom[REG_ARM] * ct, 30) + geom[REG_JOINT] + geom[REG_BASE_Z]);
            pending_q.push_back(e);
            n_items++;
        endfunction

        function void check_result(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                   logic signed [POS_W-1:0] z);
            t_tip_pos e;
            n_results++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %0d %0d %0d", x, y, z);
                return;
            end
            e = pending_q.pop_front();
            if (e.x !== x || e.y !== y || e.z !== z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                             e.x, e.y, e.z, x, y, z);
            end
        endfunction
    endclass

    logic                       i_clk = 0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [ANGLE_W-1:0]  i_pan_angle;
    logic signed [ANGLE_W-1:0]  i_tilt_angle;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [POS_W-1:0]    o_pos_x;
    logic signed [POS_W-1:0]    o_pos_y;
    logic signed [POS_W-1:0]    o_pos_z;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    tip_scoreboard sb = new();
    bit  hold_off = 0;
    int  ready_pct = 100;
    int  idle_cycles = 0;
    int  burst_left = 0;

    pan_tilt_forward_kinematics i_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_pos_x, o_pos_y, o_pos_z);
        i_ready <= !hold_off && ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        forever begin
            repeat (64) @(posedge i_clk);
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 80;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
        end
    end

    task automatic send_angles(logic signed [ANGLE_W-1:0] pan, logic signed [ANGLE_W-1:0] tilt);
        int gap;
        i_valid      <= 1'b1;
        i_pan_angle  <= pan;
        i_tilt_angle <= tilt;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(pan, tilt);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DEF_TRIG_ITERATIONS + 12) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_angles(int n);
        logic signed [ANGLE_W-1:0] p, t;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                p = ANGLE_W'($urandom);
                t = ANGLE_W'($urandom);
            end else begin
                p = ANGLE_W'($signed($urandom_range(0, 23040)) - 11520);
                t = ANGLE_W'($signed($urandom_range(0, 23040)) - 11520);
            end
            send_angles(p, t);
        end
    endtask

    initial begin
        logic signed [ANGLE_W-1:0] corners[14] = '{0, 1, -1, 5759, 5760, -5760, 11519,
            11520, -11520, 16383, -16384, 17280, -17281, 2880};
        i_rst_n = 0;
        i_valid = 0;
        i_pan_angle = 0;
        i_tilt_angle = 0;
        i_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_ARM;
        i_cfg_data = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, directed corners
        foreach (corners[k]) send_angles(corners[k], corners[(k * 5 + 3) % 14]);
        send_angles(-16384, -16384);
        send_angles(16383, 16383);
        random_angles(350);
        drain();

        // largest geometry, with a long output stall
        write_cfg(REG_ARM, 16'hFFFF);
        write_cfg(REG_BASE_X, 16'hFFFF);
        write_cfg(REG_BASE_Y, 16'hFFFF);
        write_cfg(REG_BASE_Z, 16'hFFFF);
        write_cfg(REG_JOINT, 16'hFFFF);
        write_cfg(3'd5, 16'h1234);
        write_cfg(3'd7, 16'h0000);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
        join_none
        foreach (corners[k]) send_angles(corners[k], corners[13 - k]);
        random_angles(350);
        drain();

        // zero geometry
        write_cfg(REG_ARM, 16'h0000);
        write_cfg(REG_BASE_X, 16'h0000);
        write_cfg(REG_BASE_Y, 16'h0000);
        write_cfg(REG_BASE_Z, 16'h0000);
        write_cfg(REG_JOINT, 16'h0000);
        write_cfg(3'd6, 16'hFFFF);
        random_angles(150);
        drain();

        // random geometries
        for (int ph = 0; ph < 3; ph++) begin
            for (int r = 0; r <= REG_JOINT; r++)
                write_cfg(r[CFG_IDX_W-1:0], CFG_W'($urandom));
            write_cfg(REG_ARM, CFG_W'($urandom_range(40000, 65535)));
            random_angles(220);
            drain();
        end

        $display("Checked %0d items and %0d results over six geometry settings.",
                 sb.n_items, sb.n_results);
        $display("Mismatches: %0d, left unmatched: %0d", sb.mismatches, sb.pending_q.size());
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
